// ----- sv/tpa_pkg.sv -----
// Shared widths, types and codes for the tile partition area generator.
package tpa_pkg;

	localparam int DIM_BITS   = 20;
	localparam int INDEX_BITS = 16;

	localparam int RANK_W  = 12;
	localparam int PROCS_W = 13;
	localparam int RAST_W  = DIM_BITS + 1;
	localparam int TILE_W  = 13;
	localparam int TPP_W   = 17;
	localparam int ROOT_W  = (TPP_W + 1) / 2;

	localparam int PARTS_W = RAST_W;
	localparam int TOTAL_W = 2 * PARTS_W;
	localparam int PWT_W   = TPP_W + TILE_W;
	localparam int PHT_W   = ROOT_W + TILE_W;

	localparam int GW      = INDEX_BITS + PROCS_W + 1;
	localparam int CMP_W   = (TOTAL_W > GW + 1) ? TOTAL_W : GW + 1;
	localparam int ULC_W   = PARTS_W + PWT_W;
	localparam int ULR_W   = GW + PHT_W;

	localparam int DVD_W   = ((RAST_W > TPP_W) ? RAST_W : TPP_W) + 1;
	localparam int DVS_W   = TPP_W;
	localparam int CNT_W   = $clog2(DVD_W + 1);

	localparam int DATA_W  = 32;
	localparam int PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_RANK  = 3'd0,
		REG_PROCS = 3'd1,
		REG_ROWS  = 3'd2,
		REG_COLS  = 3'd3,
		REG_TILE  = 3'd4,
		REG_TPP   = 3'd5
	} tpa_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_PW,
		ST_TD,
		ST_TA,
		ST_PD,
		ST_PA,
		ST_MUL
	} tpa_state_t;

	typedef struct packed {
		logic                 busy;
		logic                 rank_ok;
		logic [RANK_W-1:0]    rank;
		logic [PROCS_W-1:0]   procs;
		logic [TOTAL_W-1:0]   total;
		logic [PARTS_W-1:0]   pa;
		logic [PWT_W-1:0]     pwt;
		logic [PHT_W-1:0]     pht;
		logic [RAST_W-1:0]    cols_m1;
		logic [RAST_W-1:0]    rows_m1;
	} tpa_geom_t;

	typedef struct packed {
		logic hit;
		logic last;
	} tpa_side_t;

endpackage

// ----- sv/tpa_cfg.sv -----
// Register file and sequential derivation of the partition geometry.
module tpa_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tpa_pkg::PADDR_W-1:0]  paddr,
	input  logic [tpa_pkg::DATA_W-1:0]   pwdata,
	output logic [tpa_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output tpa_pkg::tpa_geom_t           geom
);

	logic [tpa_pkg::RANK_W-1:0]   rank_q;
	logic [tpa_pkg::PROCS_W-1:0]  procs_q;
	logic [tpa_pkg::RAST_W-1:0]   rows_q;
	logic [tpa_pkg::RAST_W-1:0]   cols_q;
	logic [tpa_pkg::TILE_W-1:0]   tile_q;
	logic [tpa_pkg::TPP_W-1:0]    tpp_q;

	logic [tpa_pkg::PROCS_W-1:0]  procs_e;
	logic [tpa_pkg::RAST_W-1:0]   rows_e;
	logic [tpa_pkg::RAST_W-1:0]   cols_e;
	logic [tpa_pkg::TILE_W-1:0]   tile_e;
	logic [tpa_pkg::TPP_W-1:0]    tpp_e;

	logic [tpa_pkg::ROOT_W-1:0]   root_q;
	logic [tpa_pkg::TPP_W-1:0]    pw_q;
	logic [tpa_pkg::PARTS_W-1:0]  td_q;
	logic [tpa_pkg::PARTS_W-1:0]  ta_q;
	logic [tpa_pkg::PARTS_W-1:0]  pd_q;
	logic [tpa_pkg::PARTS_W-1:0]  pa_q;
	logic [tpa_pkg::TOTAL_W-1:0]  total_q;
	logic [tpa_pkg::PWT_W-1:0]    pwt_q;
	logic [tpa_pkg::PHT_W-1:0]    pht_q;

	tpa_pkg::tpa_state_t          state_q;
	tpa_pkg::tpa_state_t          state_d;
	logic [tpa_pkg::CNT_W-1:0]    cnt_q;
	logic [tpa_pkg::DVD_W-1:0]    num_q;
	logic [tpa_pkg::DVS_W-1:0]    rem_q;

	logic                         wr;
	logic                         div_last;
	logic [tpa_pkg::DVD_W-1:0]    dvd;
	logic [tpa_pkg::DVS_W-1:0]    dvs;
	logic [tpa_pkg::DVS_W:0]      sh;
	logic                         ge;
	logic [tpa_pkg::DVS_W:0]      sh_sub;
	logic [tpa_pkg::DVS_W-1:0]    rem_n;
	logic [tpa_pkg::DVD_W-1:0]    num_n;
	logic [tpa_pkg::ROOT_W-1:0]   sq_bit;
	logic [tpa_pkg::ROOT_W-1:0]   sq_t;
	logic [2*tpa_pkg::ROOT_W-1:0] sq_p;
	logic                         sq_ok;
	tpa_pkg::tpa_reg_t            widx;

	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign widx   = tpa_pkg::tpa_reg_t'(paddr[4:2]);

	assign procs_e = (procs_q == '0) ? tpa_pkg::PROCS_W'(1) : procs_q;
	assign rows_e  = (rows_q  == '0) ? tpa_pkg::RAST_W'(1)  : rows_q;
	assign cols_e  = (cols_q  == '0) ? tpa_pkg::RAST_W'(1)  : cols_q;
	assign tile_e  = (tile_q  == '0) ? tpa_pkg::TILE_W'(1)  : tile_q;
	assign tpp_e   = (tpp_q   == '0) ? tpa_pkg::TPP_W'(1)   : tpp_q;

	// read mux
	always_comb begin
		prdata = '0;
		unique case (widx)
			tpa_pkg::REG_RANK:  prdata = tpa_pkg::DATA_W'(rank_q);
			tpa_pkg::REG_PROCS: prdata = tpa_pkg::DATA_W'(procs_q);
			tpa_pkg::REG_ROWS:  prdata = tpa_pkg::DATA_W'(rows_q);
			tpa_pkg::REG_COLS:  prdata = tpa_pkg::DATA_W'(cols_q);
			tpa_pkg::REG_TILE:  prdata = tpa_pkg::DATA_W'(tile_q);
			tpa_pkg::REG_TPP:   prdata = tpa_pkg::DATA_W'(tpp_q);
			default:            prdata = '0;
		endcase
	end

	assign div_last = (cnt_q == tpa_pkg::CNT_W'(tpa_pkg::DVD_W));

	// next state
	always_comb begin
		state_d = state_q;
		if (wr) begin
			state_d = tpa_pkg::ST_SQRT;
		end else begin
			unique case (state_q)
				tpa_pkg::ST_IDLE: state_d = tpa_pkg::ST_IDLE;
				tpa_pkg::ST_SQRT: if (cnt_q == tpa_pkg::CNT_W'(tpa_pkg::ROOT_W - 1)) begin
					state_d = tpa_pkg::ST_PW;
				end
				tpa_pkg::ST_PW: if (div_last) state_d = tpa_pkg::ST_TD;
				tpa_pkg::ST_TD: if (div_last) state_d = tpa_pkg::ST_TA;
				tpa_pkg::ST_TA: if (div_last) state_d = tpa_pkg::ST_PD;
				tpa_pkg::ST_PD: if (div_last) state_d = tpa_pkg::ST_PA;
				tpa_pkg::ST_PA: if (div_last) state_d = tpa_pkg::ST_MUL;
				tpa_pkg::ST_MUL: state_d = tpa_pkg::ST_IDLE;
				default: state_d = tpa_pkg::ST_IDLE;
			endcase
		end
	end

	// divider operand select
	always_comb begin
		dvd = '0;
		dvs = tpa_pkg::DVS_W'(1);
		unique case (state_q)
			tpa_pkg::ST_PW: begin
				dvd = tpa_pkg::DVD_W'(tpp_e);
				dvs = tpa_pkg::DVS_W'(root_q);
			end
			tpa_pkg::ST_TD: begin
				dvd = tpa_pkg::DVD_W'(rows_e) + tpa_pkg::DVD_W'(tile_e) - tpa_pkg::DVD_W'(1);
				dvs = tpa_pkg::DVS_W'(tile_e);
			end
			tpa_pkg::ST_TA: begin
				dvd = tpa_pkg::DVD_W'(cols_e) + tpa_pkg::DVD_W'(tile_e) - tpa_pkg::DVD_W'(1);
				dvs = tpa_pkg::DVS_W'(tile_e);
			end
			tpa_pkg::ST_PD: begin
				dvd = tpa_pkg::DVD_W'(td_q) + tpa_pkg::DVD_W'(root_q) - tpa_pkg::DVD_W'(1);
				dvs = tpa_pkg::DVS_W'(root_q);
			end
			tpa_pkg::ST_PA: begin
				dvd = tpa_pkg::DVD_W'(ta_q) + tpa_pkg::DVD_W'(pw_q) - tpa_pkg::DVD_W'(1);
				dvs = pw_q;
			end
			default: begin
				dvd = '0;
				dvs = tpa_pkg::DVS_W'(1);
			end
		endcase
	end

	assign sh     = {rem_q, num_q[tpa_pkg::DVD_W-1]};
	assign ge     = (sh >= {1'b0, dvs});
	assign sh_sub = sh - {1'b0, dvs};
	assign rem_n  = ge ? sh_sub[tpa_pkg::DVS_W-1:0] : sh[tpa_pkg::DVS_W-1:0];
	assign num_n  = {num_q[tpa_pkg::DVD_W-2:0], ge};

	assign sq_bit = tpa_pkg::ROOT_W'(1) << (tpa_pkg::CNT_W'(tpa_pkg::ROOT_W - 1) - cnt_q);
	assign sq_t   = root_q | sq_bit;
	assign sq_p   = (2*tpa_pkg::ROOT_W)'(sq_t) * (2*tpa_pkg::ROOT_W)'(sq_t);
	assign sq_ok  = ((2*tpa_pkg::ROOT_W+1)'(sq_p) <= (2*tpa_pkg::ROOT_W+1)'(tpp_e));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q  <= '0;
			procs_q <= tpa_pkg::PROCS_W'(1);
			rows_q  <= tpa_pkg::RAST_W'(1);
			cols_q  <= tpa_pkg::RAST_W'(1);
			tile_q  <= tpa_pkg::TILE_W'(1);
			tpp_q   <= tpa_pkg::TPP_W'(1);
			root_q  <= tpa_pkg::ROOT_W'(1);
			pw_q    <= tpa_pkg::TPP_W'(1);
			td_q    <= tpa_pkg::PARTS_W'(1);
			ta_q    <= tpa_pkg::PARTS_W'(1);
			pd_q    <= tpa_pkg::PARTS_W'(1);
			pa_q    <= tpa_pkg::PARTS_W'(1);
			total_q <= tpa_pkg::TOTAL_W'(1);
			pwt_q   <= tpa_pkg::PWT_W'(1);
			pht_q   <= tpa_pkg::PHT_W'(1);
			state_q <= tpa_pkg::ST_IDLE;
			cnt_q   <= '0;
			num_q   <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			if (wr) begin
				cnt_q  <= '0;
				root_q <= '0;
				unique case (widx)
					tpa_pkg::REG_RANK:  rank_q  <= pwdata[tpa_pkg::RANK_W-1:0];
					tpa_pkg::REG_PROCS: procs_q <= pwdata[tpa_pkg::PROCS_W-1:0];
					tpa_pkg::REG_ROWS:  rows_q  <= pwdata[tpa_pkg::RAST_W-1:0];
					tpa_pkg::REG_COLS:  cols_q  <= pwdata[tpa_pkg::RAST_W-1:0];
					tpa_pkg::REG_TILE:  tile_q  <= pwdata[tpa_pkg::TILE_W-1:0];
					tpa_pkg::REG_TPP:   tpp_q   <= pwdata[tpa_pkg::TPP_W-1:0];
					default: ;
				endcase
			end else begin
				unique case (state_q)
					tpa_pkg::ST_IDLE: ;
					tpa_pkg::ST_SQRT: begin
						if (sq_ok) root_q <= sq_t;
						if (cnt_q == tpa_pkg::CNT_W'(tpa_pkg::ROOT_W - 1)) begin
							cnt_q <= '0;
						end else begin
							cnt_q <= cnt_q + tpa_pkg::CNT_W'(1);
						end
					end
					tpa_pkg::ST_MUL: begin
						total_q <= tpa_pkg::TOTAL_W'(pd_q) * tpa_pkg::TOTAL_W'(pa_q);
						pwt_q   <= tpa_pkg::PWT_W'(pw_q) * tpa_pkg::PWT_W'(tile_e);
						pht_q   <= tpa_pkg::PHT_W'(root_q) * tpa_pkg::PHT_W'(tile_e);
					end
					default: begin
						if (cnt_q == '0) begin
							num_q <= dvd;
							rem_q <= '0;
							cnt_q <= tpa_pkg::CNT_W'(1);
						end else begin
							num_q <= num_n;
							rem_q <= rem_n;
							if (div_last) begin
								cnt_q <= '0;
								unique case (state_q)
									tpa_pkg::ST_PW: pw_q <= num_n[tpa_pkg::TPP_W-1:0];
									tpa_pkg::ST_TD: td_q <= num_n[tpa_pkg::PARTS_W-1:0];
									tpa_pkg::ST_TA: ta_q <= num_n[tpa_pkg::PARTS_W-1:0];
									tpa_pkg::ST_PD: pd_q <= num_n[tpa_pkg::PARTS_W-1:0];
									tpa_pkg::ST_PA: pa_q <= num_n[tpa_pkg::PARTS_W-1:0];
									default: ;
								endcase
							end else begin
								cnt_q <= cnt_q + tpa_pkg::CNT_W'(1);
							end
						end
					end
				endcase
			end
		end
	end

	assign geom.busy    = (state_q != tpa_pkg::ST_IDLE);
	assign geom.rank_ok = (tpa_pkg::PROCS_W'(rank_q) < procs_e);
	assign geom.rank    = rank_q;
	assign geom.procs   = procs_e;
	assign geom.total   = total_q;
	assign geom.pa      = pa_q;
	assign geom.pwt     = pwt_q;
	assign geom.pht     = pht_q;
	assign geom.cols_m1 = cols_e - tpa_pkg::RAST_W'(1);
	assign geom.rows_m1 = rows_e - tpa_pkg::RAST_W'(1);

endmodule

// ----- sv/tpa_divpipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module tpa_divpipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_v,
	input  logic [tpa_pkg::GW-1:0]       dividend,
	input  tpa_pkg::tpa_side_t           in_side,
	input  logic [tpa_pkg::PARTS_W-1:0]  divisor,
	output logic                         out_v,
	output logic [tpa_pkg::GW-1:0]       quo,
	output logic [tpa_pkg::PARTS_W-1:0]  rem,
	output tpa_pkg::tpa_side_t           out_side
);

	logic                         v_s    [tpa_pkg::GW];
	logic [tpa_pkg::GW-1:0]       num_s  [tpa_pkg::GW];
	logic [tpa_pkg::PARTS_W-1:0]  rem_s  [tpa_pkg::GW];
	tpa_pkg::tpa_side_t           side_s [tpa_pkg::GW];

	logic [tpa_pkg::GW-1:0]       num_pv [tpa_pkg::GW];
	logic [tpa_pkg::PARTS_W-1:0]  rem_pv [tpa_pkg::GW];
	logic [tpa_pkg::PARTS_W:0]    sh     [tpa_pkg::GW];
	logic [tpa_pkg::PARTS_W:0]    sub    [tpa_pkg::GW];
	logic                         ge     [tpa_pkg::GW];
	logic [tpa_pkg::GW-1:0]       num_n  [tpa_pkg::GW];
	logic [tpa_pkg::PARTS_W-1:0]  rem_n  [tpa_pkg::GW];

	always_comb begin
		for (int j = 0; j < tpa_pkg::GW; j++) begin
			if (j == 0) begin
				num_pv[j] = dividend;
				rem_pv[j] = '0;
			end else begin
				num_pv[j] = num_s[j-1];
				rem_pv[j] = rem_s[j-1];
			end
			sh[j]    = {rem_pv[j], num_pv[j][tpa_pkg::GW-1]};
			ge[j]    = (sh[j] >= {1'b0, divisor});
			sub[j]   = sh[j] - {1'b0, divisor};
			rem_n[j] = ge[j] ? sub[j][tpa_pkg::PARTS_W-1:0] : sh[j][tpa_pkg::PARTS_W-1:0];
			num_n[j] = {num_pv[j][tpa_pkg::GW-2:0], ge[j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < tpa_pkg::GW; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			for (int j = 0; j < tpa_pkg::GW; j++) begin
				v_s[j] <= (j == 0) ? in_v : v_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < tpa_pkg::GW; j++) begin
				num_s[j]  <= num_n[j];
				rem_s[j]  <= rem_n[j];
				side_s[j] <= (j == 0) ? in_side : side_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	assign out_v    = v_s[tpa_pkg::GW-1];
	assign quo      = num_s[tpa_pkg::GW-1];
	assign rem      = rem_s[tpa_pkg::GW-1];
	assign out_side = side_s[tpa_pkg::GW-1];

endmodule

// ----- sv/tile_partition_area_generator.sv -----
// Top level: per-index partition corner generator with output skid stage.
//
// Configuration goes through the APB port (six registers at byte offsets
// 0,4,...,20). Each write restarts a geometry derivation (integer square
// root, five serial divisions, three products); req_stall stays high
// during it. After reset the geometry is already valid.
// Request beats carry local_index; each yields exactly one response beat
// with valid_res, last and the clipped pixel corners of the partition.
// The pipeline is a multiply stage, an add/compare stage, one divider
// stage per bit of the global partition number, a corner multiply stage
// and a clip stage. One beat per cycle is sustained while req_stall is
// low. All stages move together; a skid register behind the last stage
// holds a beat when rsp_stall is high, and the pipeline freezes only while
// that skid register is full, so no beat is dropped or repeated.
// Reset clears all valid bits and restores the register reset values.
module tile_partition_area_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tpa_pkg::PADDR_W-1:0]     paddr,
	input  logic [tpa_pkg::DATA_W-1:0]      pwdata,
	output logic [tpa_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [tpa_pkg::INDEX_BITS-1:0]  local_index,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic                            valid_res,
	output logic                            last,
	output logic [tpa_pkg::DIM_BITS-1:0]    ul_col,
	output logic [tpa_pkg::DIM_BITS-1:0]    ul_row,
	output logic [tpa_pkg::DIM_BITS-1:0]    lr_col,
	output logic [tpa_pkg::DIM_BITS-1:0]    lr_row
);

	localparam int D = tpa_pkg::DIM_BITS;

	tpa_pkg::tpa_geom_t             geom;

	logic                           en;
	logic                           acc;

	logic                           v_s1;
	logic [tpa_pkg::GW-1:0]         kp_s1;

	logic                           v_s2;
	logic [tpa_pkg::GW-1:0]         glob_s2;
	tpa_pkg::tpa_side_t             side_s2;
	logic [tpa_pkg::GW-1:0]         glob;
	logic [tpa_pkg::CMP_W-1:0]      glob_next;

	logic                           dv;
	logic [tpa_pkg::GW-1:0]         py;
	logic [tpa_pkg::PARTS_W-1:0]    px;
	tpa_pkg::tpa_side_t             dside;

	logic                           v_s3;
	logic [tpa_pkg::ULC_W-1:0]      ulc_s3;
	logic [tpa_pkg::ULR_W-1:0]      ulr_s3;
	tpa_pkg::tpa_side_t             side_s3;

	logic [tpa_pkg::ULC_W:0]        lrc_raw;
	logic [tpa_pkg::ULR_W:0]        lrr_raw;
	logic [tpa_pkg::ULC_W:0]        lrc_clip;
	logic [tpa_pkg::ULR_W:0]        lrr_clip;

	logic                           v_s4;
	logic                           hit_s4;
	logic                           last_s4;
	logic [D-1:0]                   ulc_s4;
	logic [D-1:0]                   ulr_s4;
	logic [D-1:0]                   lrc_s4;
	logic [D-1:0]                   lrr_s4;

	logic                           skid_q;
	logic                           hit_q;
	logic                           last_q;
	logic [D-1:0]                   ulc_q;
	logic [D-1:0]                   ulr_q;
	logic [D-1:0]                   lrc_q;
	logic [D-1:0]                   lrr_q;

	tpa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom)
	);

	assign en        = !skid_q;
	assign req_stall = geom.busy || skid_q;
	assign acc       = req_valid && !req_stall;

	assign glob      = tpa_pkg::GW'(geom.rank) + kp_s1;
	assign glob_next = tpa_pkg::CMP_W'(glob) + tpa_pkg::CMP_W'(geom.procs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= dv;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kp_s1        <= tpa_pkg::GW'(local_index) * tpa_pkg::GW'(geom.procs);
			glob_s2      <= glob;
			side_s2.hit  <= geom.rank_ok &&
				(tpa_pkg::CMP_W'(glob) < tpa_pkg::CMP_W'(geom.total));
			side_s2.last <= (glob_next >= tpa_pkg::CMP_W'(geom.total));
			ulc_s3       <= tpa_pkg::ULC_W'(px) * tpa_pkg::ULC_W'(geom.pwt);
			ulr_s3       <= tpa_pkg::ULR_W'(py) * tpa_pkg::ULR_W'(geom.pht);
			side_s3      <= dside;
		end
	end

	tpa_divpipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s2),
		.dividend (glob_s2),
		.in_side  (side_s2),
		.divisor  (geom.pa),
		.out_v    (dv),
		.quo      (py),
		.rem      (px),
		.out_side (dside)
	);

	// clip lower-right corner to the raster
	assign lrc_raw  = (tpa_pkg::ULC_W+1)'(ulc_s3) + (tpa_pkg::ULC_W+1)'(geom.pwt)
		- (tpa_pkg::ULC_W+1)'(1);
	assign lrr_raw  = (tpa_pkg::ULR_W+1)'(ulr_s3) + (tpa_pkg::ULR_W+1)'(geom.pht)
		- (tpa_pkg::ULR_W+1)'(1);
	assign lrc_clip = (lrc_raw > (tpa_pkg::ULC_W+1)'(geom.cols_m1)) ?
		(tpa_pkg::ULC_W+1)'(geom.cols_m1) : lrc_raw;
	assign lrr_clip = (lrr_raw > (tpa_pkg::ULR_W+1)'(geom.rows_m1)) ?
		(tpa_pkg::ULR_W+1)'(geom.rows_m1) : lrr_raw;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4  <= side_s3.hit;
			last_s4 <= side_s3.hit && side_s3.last;
			ulc_s4  <= side_s3.hit ? ulc_s3[D-1:0]   : '0;
			ulr_s4  <= side_s3.hit ? ulr_s3[D-1:0]   : '0;
			lrc_s4  <= side_s3.hit ? lrc_clip[D-1:0] : '0;
			lrr_s4  <= side_s3.hit ? lrr_clip[D-1:0] : '0;
		end
	end

	// skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			if (!rsp_stall) skid_q <= 1'b0;
		end else if (v_s4 && rsp_stall) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			hit_q  <= hit_s4;
			last_q <= last_s4;
			ulc_q  <= ulc_s4;
			ulr_q  <= ulr_s4;
			lrc_q  <= lrc_s4;
			lrr_q  <= lrr_s4;
		end
	end

	assign rsp_valid = skid_q || v_s4;
	assign valid_res = skid_q ? hit_q  : hit_s4;
	assign last      = skid_q ? last_q : last_s4;
	assign ul_col    = skid_q ? ulc_q  : ulc_s4;
	assign ul_row    = skid_q ? ulr_q  : ulr_s4;
	assign lr_col    = skid_q ? lrc_q  : lrc_s4;
	assign lr_row    = skid_q ? lrr_q  : lrr_s4;

endmodule

// ----- sv/tpa_checker.sv -----
// Port-level checker for the tile partition area generator, with bind.
module tpa_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic                            req_stall,
	input  logic                            rsp_valid,
	input  logic                            rsp_stall,
	input  logic                            valid_res,
	input  logic                            last,
	input  logic [tpa_pkg::DIM_BITS-1:0]    ul_col,
	input  logic [tpa_pkg::DIM_BITS-1:0]    ul_row,
	input  logic [tpa_pkg::DIM_BITS-1:0]    lr_col,
	input  logic [tpa_pkg::DIM_BITS-1:0]    lr_row
);

	// stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(ul_col) && $stable(ul_row)
			&& $stable(lr_col) && $stable(lr_row) && $stable(valid_res) && $stable(last))
		else $error("response beat changed while stalled");

	// absent partition reports zero fields
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !valid_res |-> !last && ul_col == '0 && ul_row == '0
			&& lr_col == '0 && lr_row == '0)
		else $error("nonzero fields on absent partition");

	// register write blocks requests while geometry is rederived
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=> req_stall)
		else $error("request taken during geometry update");

endmodule

bind tile_partition_area_generator tpa_checker u_tpa_checker (.*);

// ----- dv/tb_tile_partition_area_generator.sv -----
// Testbench for the tile partition area generator: index beats against a predictor.
module tb_tile_partition_area_generator;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic                         vld;
		logic                         lst;
		logic [tpa_pkg::DIM_BITS-1:0] ulc;
		logic [tpa_pkg::DIM_BITS-1:0] ulr;
		logic [tpa_pkg::DIM_BITS-1:0] lrc;
		logic [tpa_pkg::DIM_BITS-1:0] lrr;
	} area_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [tpa_pkg::PADDR_W-1:0] paddr = '0;
	logic [tpa_pkg::DATA_W-1:0] pwdata = '0;
	logic [tpa_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [tpa_pkg::INDEX_BITS-1:0] local_index = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic valid_res, last;
	logic [tpa_pkg::DIM_BITS-1:0] ul_col, ul_row, lr_col, lr_row;

	tile_partition_area_generator dut (.*);

	always #4 clk = ~clk;

	longint unsigned rank_r, procs_r, rows_r, cols_r, tile_r, tpp_r;
	logic [tpa_pkg::INDEX_BITS-1:0] index_q[$];
	area_t area_q[$];
	logic req_acc_q = 1'b0;
	int errors = 0;
	longint cycles = 0;
	int gap = 0;
	int sgap = 0;

	function automatic void queue_index(logic [tpa_pkg::INDEX_BITS-1:0] v);
		index_q = {index_q, v};
	endfunction

	// partition geometry for the current register values
	function automatic area_t predict_area(longint unsigned k);
		area_t a;
		longint unsigned procs, rows, cols, tile, tpp, ph, pw, td, ta, pd, pa, total, g;
		longint unsigned py, px, c0, r0, c1, r1;
		procs = procs_r == 0 ? 1 : procs_r;
		rows = rows_r == 0 ? 1 : rows_r;
		cols = cols_r == 0 ? 1 : cols_r;
		tile = tile_r == 0 ? 1 : tile_r;
		tpp = tpp_r == 0 ? 1 : tpp_r;
		ph = 0;
		for (int b = 20; b >= 0; b--)
			if (((ph | (64'd1 << b)) * (ph | (64'd1 << b))) <= tpp)
				ph = ph | (64'd1 << b);
		pw = tpp / ph;
		td = (rows + tile - 1) / tile;
		ta = (cols + tile - 1) / tile;
		pd = (td + ph - 1) / ph;
		pa = (ta + pw - 1) / pw;
		total = pd * pa;
		g = rank_r + k * procs;
		a = '{1'b0, 1'b0, '0, '0, '0, '0};
		if (rank_r < procs && g < total) begin
			py = g / pa;
			px = g % pa;
			c0 = px * pw * tile;
			r0 = py * ph * tile;
			c1 = c0 + pw * tile - 1;
			r1 = r0 + ph * tile - 1;
			if (c1 > cols - 1) c1 = cols - 1;
			if (r1 > rows - 1) r1 = rows - 1;
			a.vld = 1'b1;
			a.lst = (g + procs >= total);
			a.ulc = c0[tpa_pkg::DIM_BITS-1:0];
			a.ulr = r0[tpa_pkg::DIM_BITS-1:0];
			a.lrc = c1[tpa_pkg::DIM_BITS-1:0];
			a.lrr = r1[tpa_pkg::DIM_BITS-1:0];
		end
		return a;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// request beat taken at this rising edge
	always @(posedge clk) begin
		req_acc_q <= arst_n && req_valid && !req_stall;
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_acc_q) begin
				void'(index_q.pop_front());
				gap = pick_gap();
			end
			if (req_valid && !req_acc_q) begin
			end else if (gap > 0) begin
				gap--;
				req_valid <= 1'b0;
			end else if (index_q.size() > 0) begin
				req_valid <= 1'b1;
				local_index <= index_q[0];
			end else begin
				req_valid <= 1'b0;
			end
			if (sgap > 0) begin
				sgap--;
				rsp_stall <= 1'b1;
			end else begin
				sgap = pick_gap();
				rsp_stall <= 1'b0;
			end
		end
	end

	// predict on accepted requests, check accepted responses
	always @(posedge clk) begin
		area_t e;
		if (arst_n && req_valid && !req_stall)
			area_q = {area_q, predict_area(local_index)};
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (area_q.size() == 0) begin
				$error("response beat with nothing expected");
				errors++;
			end else begin
				e = area_q.pop_front();
				if (valid_res !== e.vld) begin
					$error("valid_res exp %0d got %0d", e.vld, valid_res); errors++;
				end
				if (last !== e.lst) begin
					$error("last exp %0d got %0d", e.lst, last); errors++;
				end
				if (ul_col !== e.ulc) begin
					$error("ul_col exp %0d got %0d", e.ulc, ul_col); errors++;
				end
				if (ul_row !== e.ulr) begin
					$error("ul_row exp %0d got %0d", e.ulr, ul_row); errors++;
				end
				if (lr_col !== e.lrc) begin
					$error("lr_col exp %0d got %0d", e.lrc, lr_col); errors++;
				end
				if (lr_row !== e.lrr) begin
					$error("lr_row exp %0d got %0d", e.lrr, lr_row); errors++;
				end
			end
		end
	end

	task automatic reg_write(tpa_pkg::tpa_reg_t r, longint unsigned v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= tpa_pkg::PADDR_W'(4 * int'(r)); pwdata <= tpa_pkg::DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (r)
			tpa_pkg::REG_RANK:  rank_r = v & 64'hfff;
			tpa_pkg::REG_PROCS: procs_r = v & 64'h1fff;
			tpa_pkg::REG_ROWS:  rows_r = v & 64'h1fffff;
			tpa_pkg::REG_COLS:  cols_r = v & 64'h1fffff;
			tpa_pkg::REG_TILE:  tile_r = v & 64'h1fff;
			default:            tpp_r = v & 64'h1ffff;
		endcase
	endtask

	task automatic drain();
		while (index_q.size() > 0 || area_q.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_geometry(longint unsigned rk, pr, rw, cl, te, tp);
		reg_write(tpa_pkg::REG_RANK, rk);
		reg_write(tpa_pkg::REG_PROCS, pr);
		reg_write(tpa_pkg::REG_ROWS, rw);
		reg_write(tpa_pkg::REG_COLS, cl);
		reg_write(tpa_pkg::REG_TILE, te);
		reg_write(tpa_pkg::REG_TPP, tp);
	endtask

	// mostly small indices from 0 to 40, some anywhere
	task automatic load_indices(int n);
		for (int i = 0; i < n; i++)
			queue_index($urandom_range(0, 3) == 0 ? tpa_pkg::INDEX_BITS'($urandom)
				: tpa_pkg::INDEX_BITS'($urandom_range(0, 40)));
	endtask

	initial begin
		rank_r = 0; procs_r = 1; rows_r = 1; cols_r = 1; tile_r = 1; tpp_r = 1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		queue_index('0);
		queue_index(tpa_pkg::INDEX_BITS'(1));
		queue_index('1);
		drain();
		set_geometry(0, 1, 100, 130, 8, 6);
		for (int i = 0; i < 12; i++) queue_index(tpa_pkg::INDEX_BITS'(i));
		queue_index('1);
		drain();
		set_geometry(4095, 4096, 1048576, 1048576, 4096, 65536);
		queue_index('0); queue_index(tpa_pkg::INDEX_BITS'(1)); queue_index('1);
		drain();
		set_geometry(5, 3, 1048576, 1048576, 1, 1);
		queue_index('0); queue_index(tpa_pkg::INDEX_BITS'(16'h8000)); queue_index('1);
		drain();
		set_geometry(2, 3, 0, 0, 0, 0);
		queue_index('0); queue_index(tpa_pkg::INDEX_BITS'(1));
		drain();
		for (int p = 0; p < 12; p++) begin
			longint unsigned pr;
			pr = $urandom_range(1, 8);
			set_geometry($urandom_range(0, pr), pr, $urandom_range(1, 4000),
				$urandom_range(1, 4000), $urandom_range(1, 64), $urandom_range(1, 40));
			load_indices(90);
			drain();
		end
		set_geometry($urandom_range(0, 4095), $urandom_range(1, 4096),
			$urandom_range(1, 1048576), $urandom_range(1, 1048576),
			$urandom_range(1, 4096), $urandom_range(1, 65536));
		load_indices(100);
		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ----- tile_partition_area_generator.f -----
sv/tpa_pkg.sv
sv/tpa_cfg.sv
sv/tpa_divpipe.sv
sv/tile_partition_area_generator.sv
sv/tpa_checker.sv
dv/tb_tile_partition_area_generator.sv
